### design/ptc_pkg.sv
// Shared types, codes and constants of the periodic timer channel block.
// No dependencies; every other design file refers to it by scoped names.
package ptc_pkg;

  localparam int CHANNELS = 8;
  localparam int CHAN_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MASK_W   = 8;

  typedef logic [2:0]  func_t;
  typedef logic [3:0]  unit_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] period_t;

  localparam func_t FUNC_TICK   = 3'd0;
  localparam func_t FUNC_CREATE = 3'd1;
  localparam func_t FUNC_START  = 3'd2;
  localparam func_t FUNC_STOP   = 3'd3;
  localparam func_t FUNC_DELETE = 3'd4;

  localparam unit_t UNIT_TICK  = 4'd0;
  localparam unit_t UNIT_US    = 4'd1;
  localparam unit_t UNIT_MS    = 4'd2;
  localparam unit_t UNIT_S     = 4'd3;
  localparam unit_t UNIT_MIN   = 4'd4;
  localparam unit_t UNIT_HOUR  = 4'd5;
  localparam unit_t UNIT_DAY   = 4'd6;
  localparam unit_t UNIT_MONTH = 4'd7;
  localparam unit_t UNIT_YEAR  = 4'd8;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_ZERO_PERIOD = 2'd1;
  localparam status_t ST_ABSENT      = 2'd2;

  // Last value of each cascade stage before it rolls over
  localparam logic [9:0] MICRO_LAST  = 10'd999;
  localparam logic [9:0] MILLI_LAST  = 10'd999;
  localparam logic [5:0] SECOND_LAST = 6'd59;
  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [4:0] DAY_LAST    = 5'd29;

  typedef struct packed {
    logic [31:0] ticks;
    logic [9:0]  micro;
    logic [9:0]  milli;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [31:0] month;
  } time_t;

  // Current count in the given unit; no year count is kept, unknown codes read ms
  function automatic logic [31:0] time_in_unit(time_t t, unit_t u);
    logic [31:0] v;
    case (u)
      UNIT_TICK:  v = t.ticks;
      UNIT_US:    v = 32'(t.micro);
      UNIT_MS:    v = 32'(t.milli);
      UNIT_S:     v = 32'(t.second);
      UNIT_MIN:   v = 32'(t.minute);
      UNIT_HOUR:  v = 32'(t.hour);
      UNIT_DAY:   v = 32'(t.day);
      UNIT_MONTH: v = t.month;
      UNIT_YEAR:  v = 32'd0;
      default:    v = 32'(t.milli);
    endcase
    return v;
  endfunction

endpackage

### design/ptc_if.sv
// Valid/ready channel interfaces for command words and result words.
// Depends on ptc_pkg for the payload types.
interface ptc_cmd_if;
  logic              valid;
  logic              ready;
  ptc_pkg::func_t    func;
  logic [2:0]        channel;
  ptc_pkg::period_t  period;
  ptc_pkg::unit_t    time_unit;

  modport source (output valid, func, channel, period, time_unit, input ready);
  modport sink   (input valid, func, channel, period, time_unit, output ready);
endinterface

interface ptc_res_if;
  logic              valid;
  logic              ready;
  logic [7:0]        expired_mask;
  ptc_pkg::status_t  status;

  modport source (output valid, expired_mask, status, input ready);
  modport sink   (input valid, expired_mask, status, output ready);
endinterface

### design/ptc_clock.sv
// Tick counter, prescaler and time-of-day cascade (us, ms, s, min, hour, day, month).
// Depends on ptc_pkg for time_t and the rollover constants.
module ptc_clock (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [15:0]    ticks_per_us,
  output ptc_pkg::time_t time_next
);

  ptc_pkg::time_t cur;
  logic [15:0]    prescale;
  logic [15:0]    prescale_next;
  logic [16:0]    pre_inc;
  logic [15:0]    limit;
  logic           fire;
  logic           c_micro, c_milli, c_second, c_minute, c_hour, c_day;

  always_comb begin
    limit   = (ticks_per_us == 16'd0) ? 16'd1 : ticks_per_us;
    pre_inc = {1'b0, prescale} + 17'd1;
    fire    = (pre_inc >= {1'b0, limit});
    prescale_next = fire ? 16'd0 : pre_inc[15:0];

    // carry only on rollover of the stage below
    c_micro  = fire && (cur.micro == ptc_pkg::MICRO_LAST);
    c_milli  = c_micro && (cur.milli == ptc_pkg::MILLI_LAST);
    c_second = c_milli && (cur.second == ptc_pkg::SECOND_LAST);
    c_minute = c_second && (cur.minute == ptc_pkg::MINUTE_LAST);
    c_hour   = c_minute && (cur.hour == ptc_pkg::HOUR_LAST);
    c_day    = c_hour && (cur.day == ptc_pkg::DAY_LAST);

    time_next       = cur;
    time_next.ticks = cur.ticks + 32'd1;
    if (fire)     time_next.micro  = c_micro  ? 10'd0 : cur.micro + 10'd1;
    if (c_micro)  time_next.milli  = c_milli  ? 10'd0 : cur.milli + 10'd1;
    if (c_milli)  time_next.second = c_second ? 6'd0  : cur.second + 6'd1;
    if (c_second) time_next.minute = c_minute ? 6'd0  : cur.minute + 6'd1;
    if (c_minute) time_next.hour   = c_hour   ? 5'd0  : cur.hour + 5'd1;
    if (c_hour)   time_next.day    = c_day    ? 5'd0  : cur.day + 5'd1;
    if (c_day)    time_next.month  = cur.month + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= '0;
      prescale <= 16'd0;
    end else if (step) begin
      cur      <= time_next;
      prescale <= prescale_next;
    end
  end

endmodule

### design/periodic_timer_channels_with_clock.sv
// Periodic timer channels with a time-of-day clock. Each command word is one of
// tick, create, start, stop or delete, and gives exactly one result word back:
// an expiry mask (tick words only) and a status. A tick advances a 32-bit tick
// count and a prescaler; every ticks_per_microsecond ticks (zero acts as one)
// the cascade steps microseconds up through a 32-bit month count, 30 days to a
// month. Every present, running channel then compares the elapsed time in its
// unit, modulo 2^32, with its period, and on expiry sets its mask bit and
// restarts from the current count. The block takes one word per clock while
// results are being taken: a word is held in an input register, does all its
// work in one pass through the cascade and the eight parallel channel compares,
// and then lands in the result register. Back-pressure on the result side
// stalls the input register, which still frees up whenever the result register
// is being emptied. Write ticks_per_microsecond via cfg_write and cfg_data only
// while no word is in flight. After reset channel 0 is present and running with
// a period of one millisecond.
module periodic_timer_channels_with_clock (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  ptc_cmd_if.sink     cmd,
  ptc_res_if.source   res
);

  localparam int CH = ptc_pkg::CHANNELS;
  localparam int CW = ptc_pkg::CHAN_W;
  localparam int MW = ptc_pkg::MASK_W;

  // configuration
  logic [15:0] ticks_per_us;

  // input register
  logic              a_valid;
  ptc_pkg::func_t    a_func;
  logic [2:0]        a_channel;
  ptc_pkg::period_t  a_period;
  ptc_pkg::unit_t    a_unit;
  logic              adv;

  // result register
  logic              out_valid;
  logic [MW-1:0]     out_mask;
  ptc_pkg::status_t  out_status;

  // channel table
  logic [CH-1:0]     chan_present, chan_present_next;
  logic [CH-1:0]     chan_running, chan_running_next;
  ptc_pkg::period_t  chan_period [CH];
  ptc_pkg::period_t  chan_period_next [CH];
  ptc_pkg::unit_t    chan_unit [CH];
  ptc_pkg::unit_t    chan_unit_next [CH];
  logic [31:0]       chan_last [CH];
  logic [31:0]       chan_last_next [CH];

  logic              tick_step;
  ptc_pkg::time_t    time_next;
  logic              ch_ok;
  logic [CW-1:0]     idx;
  logic [MW-1:0]     mask;
  ptc_pkg::status_t  status;

  assign adv       = a_valid && (!out_valid || res.ready);
  assign cmd.ready = !a_valid || adv;
  assign tick_step = adv && (a_func == ptc_pkg::FUNC_TICK);

  assign res.valid        = out_valid;
  assign res.expired_mask = out_mask;
  assign res.status       = out_status;

  ptc_clock u_clock (
    .clk          (clk),
    .rst          (rst),
    .step         (tick_step),
    .ticks_per_us (ticks_per_us),
    .time_next    (time_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= 16'd1;
    end else if (cfg_write) begin
      ticks_per_us <= cfg_data;
    end
  end

  // Hold the word until the pass below can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd.ready) begin
      a_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      a_func    <= cmd.func;
      a_channel <= cmd.channel;
      a_period  <= cmd.period;
      a_unit    <= cmd.time_unit;
    end
  end

  assign ch_ok = ({29'd0, a_channel} < 32'(CH));
  assign idx   = CW'(a_channel);

  always_comb begin
    logic [31:0] now;
    logic [31:0] elapsed;
    chan_present_next = chan_present;
    chan_running_next = chan_running;
    chan_period_next  = chan_period;
    chan_unit_next    = chan_unit;
    chan_last_next    = chan_last;
    mask    = '0;
    status  = ptc_pkg::ST_OK;
    now     = '0;
    elapsed = '0;
    case (a_func)
      ptc_pkg::FUNC_TICK: begin
        // check every present, running channel against the clock after this tick's step
        for (int i = 0; i < CH; i++) begin
          if (chan_present[i] && chan_running[i]) begin
            now     = ptc_pkg::time_in_unit(time_next, chan_unit[i]);
            elapsed = now - chan_last[i];
            if (elapsed >= chan_period[i]) begin
              chan_last_next[i] = now;
              if (i < MW) mask = mask | (MW'(1) << i);
            end
          end
        end
      end
      ptc_pkg::FUNC_CREATE: begin
        if (!ch_ok) begin
          status = ptc_pkg::ST_ABSENT;
        end else if (a_period == 32'd0) begin
          status = ptc_pkg::ST_ZERO_PERIOD;
        end else begin
          chan_present_next[idx] = 1'b1;
          chan_running_next[idx] = 1'b0;
          chan_period_next[idx]  = a_period;
          chan_unit_next[idx]    = a_unit;
          chan_last_next[idx]    = 32'd0;
        end
      end
      ptc_pkg::FUNC_START, ptc_pkg::FUNC_STOP, ptc_pkg::FUNC_DELETE: begin
        if (!ch_ok || !chan_present[idx]) begin
          status = ptc_pkg::ST_ABSENT;
        end else if (a_func == ptc_pkg::FUNC_START) begin
          chan_running_next[idx] = 1'b1;
        end else if (a_func == ptc_pkg::FUNC_STOP) begin
          chan_running_next[idx] = 1'b0;
        end else begin
          chan_present_next[idx] = 1'b0;
          chan_running_next[idx] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the table and the result register together
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_present <= CH'(1);
      chan_running <= CH'(1);
      for (int i = 0; i < CH; i++) begin
        chan_period[i] <= (i == 0) ? 32'd1 : 32'd0;
        chan_unit[i]   <= ptc_pkg::UNIT_MS;
        chan_last[i]   <= 32'd0;
      end
    end else if (adv) begin
      chan_present <= chan_present_next;
      chan_running <= chan_running_next;
      chan_period  <= chan_period_next;
      chan_unit    <= chan_unit_next;
      chan_last    <= chan_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      out_mask   <= mask;
      out_status <= status;
    end
  end

`ifndef SYNTHESIS
  a_running_needs_present: assert property (@(posedge clk) disable iff (rst)
    (chan_running & ~chan_present) == '0)
    else $error("channel running while not present");

  a_non_tick_mask_clear: assert property (@(posedge clk) disable iff (rst)
    adv && (a_func != ptc_pkg::FUNC_TICK) |=> res.valid && (res.expired_mask == '0))
    else $error("expiry mask set on a non-tick word");

  a_tick_status_ok: assert property (@(posedge clk) disable iff (rst)
    tick_step |=> res.valid && (res.status == ptc_pkg::ST_OK))
    else $error("tick word gave a non-ok status");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> a_valid && out_valid && !res.ready)
    else $error("input stalled while the pass was free");
`endif

endmodule
